// ===== rtl/rcc_pkg.sv =====
// Shared types and constants for the reservation conflict checker.
`default_nettype none

package rcc_pkg;

   localparam int SLOT_BITS  = 10;
   localparam int ID_BITS    = 32;
   localparam int BATCH_BITS = 16;
   localparam int SLOT_COUNT = 1 << SLOT_BITS;

   typedef enum logic [1:0] {
      CMD_RESERVE_READ  = 2'd0,
      CMD_RESERVE_WRITE = 2'd1,
      CMD_VERIFY_READ   = 2'd2,
      CMD_VERIFY_WRITE  = 2'd3
   } cmd_type;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [ID_BITS-1:0]    id_type;
   typedef logic [BATCH_BITS-1:0] batch_type;

   typedef struct packed {
      cmd_type   cmd;
      slot_type  key_slot;
      id_type    txn_id;
      batch_type batch_tag;
      logic      last_key;
   } req_type;

   typedef struct packed {
      logic raw_hit;
      logic war_hit;
      logic waw_hit;
      logic conflict;
   } rsp_type;

   // One reservation as stored in a table row.
   typedef struct packed {
      logic      valid;
      batch_type batch;
      id_type    id;
   } entry_type;

   // Write command from the control path to one table.
   typedef struct packed {
      logic      en;
      slot_type  slot;
      entry_type entry;
   } tbl_wr_type;

   // Configuration register byte addresses.
   localparam logic [1:0] CSR_REORDER_ENABLE = 2'd0;

endpackage

`default_nettype wire

// ===== rtl/rcc_table.sv =====
// Reservation table: synchronous memory with write-to-read forwarding.
`default_nettype none

module rcc_table (
   input  wire               clock,
   input  wire               reset,
   input  wire               rd_en,
   input  rcc_pkg::slot_type rd_slot,
   input  rcc_pkg::tbl_wr_type wr_cmd,
   output rcc_pkg::entry_type rd_entry
);

   rcc_pkg::entry_type table_mem [rcc_pkg::SLOT_COUNT];

   rcc_pkg::entry_type q_ff;
   rcc_pkg::slot_type  rd_slot_ff;
   logic               fwd_valid_ff;
   rcc_pkg::slot_type  fwd_slot_ff;
   rcc_pkg::entry_type fwd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.en) begin
         table_mem[wr_cmd.slot] <= wr_cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff       <= table_mem[rd_slot];
         rd_slot_ff <= rd_slot;
      end
   end

   // Last write always matches memory, so keeping it around is safe.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_cmd.en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.en) begin
         fwd_slot_ff  <= wr_cmd.slot;
         fwd_entry_ff <= wr_cmd.entry;
      end
   end

   assign rd_entry = (fwd_valid_ff && (fwd_slot_ff == rd_slot_ff)) ? fwd_entry_ff : q_ff;

endmodule

`default_nettype wire

// ===== rtl/rcc_ctrl.sv =====
// Control path: clearing sweep, check stage, hit flags and result register.
`default_nettype none

module rcc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  reorder_enable,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  rcc_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output rcc_pkg::rsp_type     rsp_data,
   output logic                 rd_en,
   input  rcc_pkg::entry_type   rd_q,
   input  rcc_pkg::entry_type   wr_q,
   output rcc_pkg::tbl_wr_type  rd_tbl_wr,
   output rcc_pkg::tbl_wr_type  wr_tbl_wr
);

   logic              clear_ff, clear_in;
   rcc_pkg::slot_type clear_idx_ff, clear_idx_in;

   logic             s1_valid_ff, s1_valid_in;
   rcc_pkg::req_type s1_item_ff;

   logic raw_seen_ff, raw_seen_in;
   logic war_seen_ff, war_seen_in;
   logic waw_seen_ff, waw_seen_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rcc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept, s1_has_rsp, hold, s1_done, rsp_load;
   logic rd_other, wr_other, rd_take, wr_take;
   logic raw_n, war_n, waw_n;
   rcc_pkg::entry_type new_entry;

   // Hit and takeover tests against the (forwarded) table rows.
   assign rd_other = rd_q.valid && (rd_q.batch == s1_item_ff.batch_tag)
                     && (rd_q.id != s1_item_ff.txn_id);
   assign wr_other = wr_q.valid && (wr_q.batch == s1_item_ff.batch_tag)
                     && (wr_q.id != s1_item_ff.txn_id);
   assign rd_take  = !rd_q.valid || (rd_q.batch != s1_item_ff.batch_tag)
                     || (rd_q.id > s1_item_ff.txn_id);
   assign wr_take  = !wr_q.valid || (wr_q.batch != s1_item_ff.batch_tag)
                     || (wr_q.id > s1_item_ff.txn_id);

   assign s1_has_rsp = s1_item_ff.last_key
                       && ((s1_item_ff.cmd == rcc_pkg::CMD_VERIFY_READ)
                           || (s1_item_ff.cmd == rcc_pkg::CMD_VERIFY_WRITE));
   // A finished verify can't leave while the result register is stuck.
   assign hold      = s1_valid_ff && s1_has_rsp && rsp_valid_ff && rsp_stall;
   assign s1_done   = s1_valid_ff && !hold;
   assign req_stall = clear_ff || hold;
   assign accept    = req_valid && !req_stall;
   assign rd_en     = accept;
   assign rsp_load  = s1_done && s1_has_rsp;

   assign new_entry = '{valid: 1'b1, batch: s1_item_ff.batch_tag, id: s1_item_ff.txn_id};

   always_comb begin
      raw_n = raw_seen_ff;
      war_n = war_seen_ff;
      waw_n = waw_seen_ff;
      rd_tbl_wr = '{en: 1'b0, slot: s1_item_ff.key_slot, entry: new_entry};
      wr_tbl_wr = '{en: 1'b0, slot: s1_item_ff.key_slot, entry: new_entry};
      unique case (s1_item_ff.cmd)
         rcc_pkg::CMD_RESERVE_READ: begin
            rd_tbl_wr.en = s1_done && rd_take;
         end
         rcc_pkg::CMD_RESERVE_WRITE: begin
            wr_tbl_wr.en = s1_done && wr_take;
         end
         rcc_pkg::CMD_VERIFY_READ: begin
            raw_n = raw_seen_ff || wr_other;
         end
         rcc_pkg::CMD_VERIFY_WRITE: begin
            war_n = war_seen_ff || rd_other;
            waw_n = waw_seen_ff || wr_other;
         end
         default: begin
         end
      endcase
      // Sweep owns both write ports right after reset.
      if (clear_ff) begin
         rd_tbl_wr = '{en: 1'b1, slot: clear_idx_ff, entry: '0};
         wr_tbl_wr = '{en: 1'b1, slot: clear_idx_ff, entry: '0};
      end
   end

   always_comb begin
      clear_in     = clear_ff && (clear_idx_ff != '1);
      clear_idx_in = clear_ff ? clear_idx_ff + rcc_pkg::slot_type'(1) : clear_idx_ff;
      s1_valid_in  = accept || hold;

      raw_seen_in = raw_seen_ff;
      war_seen_in = war_seen_ff;
      waw_seen_in = waw_seen_ff;
      if (s1_done) begin
         raw_seen_in = s1_has_rsp ? 1'b0 : raw_n;
         war_seen_in = s1_has_rsp ? 1'b0 : war_n;
         waw_seen_in = s1_has_rsp ? 1'b0 : waw_n;
      end

      rsp_data_in = '{raw_hit: raw_n, war_hit: war_n, waw_hit: waw_n,
                      conflict: waw_n || (reorder_enable ? (raw_n && war_n) : war_n)};
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
         s1_valid_ff  <= 1'b0;
         raw_seen_ff  <= 1'b0;
         war_seen_ff  <= 1'b0;
         waw_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_idx_ff <= clear_idx_in;
         s1_valid_ff  <= s1_valid_in;
         raw_seen_ff  <= raw_seen_in;
         war_seen_ff  <= war_seen_in;
         waw_seen_ff  <= waw_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sweep runs once after reset and never restarts.
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clear_ff |=> !clear_ff)
      else $error("clearing sweep restarted");

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("result register overwritten while stalled");

   // Flags start fresh for the next transaction.
   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (!raw_seen_ff && !war_seen_ff && !waw_seen_ff))
      else $error("hit flags not cleared after result");

   // Conflict needs a write-side hit under either rule.
   a_conflict_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.conflict || rsp_data_ff.waw_hit || rsp_data_ff.war_hit))
      else $error("conflict without war or waw hit");

   // No table write from an item while the sweep owns the tables.
   a_no_item_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_valid_ff)
      else $error("item in flight during clearing sweep");

endmodule

`default_nettype wire

// ===== rtl/reservation_conflict_checker.sv =====
// Top level: config register, control path and the read/write reservation tables.
//
//   channel | direction | handshake                | payload
//   req     | in        | req_valid / req_stall    | req_data  (cmd, key_slot, txn_id, ...)
//   rsp     | out       | rsp_valid / rsp_stall    | rsp_data  (raw/war/waw hit, conflict)
//   csr     | in/out    | psel, penable, pready    | paddr, pwdata, prdata
//
// One item per cycle when req is not stalled; each item is one read-modify-write
// of a table row, the second memory port's write forwarded into the next read of
// the same row. An item is checked the cycle after its transfer; a last-key verify
// item's result is then loaded into the result register that drives rsp_valid/rsp_data.
// After reset a sweep clears all 2**SLOT_BITS (1024) rows of both tables, req stalled.
// A stalled result with another result behind it holds that item and stalls req.
`default_nettype none

module reservation_conflict_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  rcc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output rcc_pkg::rsp_type  rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [1:0]        paddr,
   input  wire  [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic reorder_enable_ff, reorder_enable_in;
   logic csr_write;

   logic                rd_en;
   rcc_pkg::entry_type  rd_q, wr_q;
   rcc_pkg::tbl_wr_type rd_tbl_wr, wr_tbl_wr;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Single word register: low address bits are byte lanes.
   always_comb begin
      reorder_enable_in = reorder_enable_ff;
      if (csr_write) begin
         reorder_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reorder_enable_ff <= 1'b0;
      end else begin
         reorder_enable_ff <= reorder_enable_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == rcc_pkg::CSR_REORDER_ENABLE) begin
         prdata = {31'b0, reorder_enable_ff};
      end else begin
         prdata = {31'b0, reorder_enable_ff};
      end
   end

   rcc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .reorder_enable (reorder_enable_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .rd_en          (rd_en),
      .rd_q           (rd_q),
      .wr_q           (wr_q),
      .rd_tbl_wr      (rd_tbl_wr),
      .wr_tbl_wr      (wr_tbl_wr)
   );

   rcc_table u_read_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_slot  (req_data.key_slot),
      .wr_cmd   (rd_tbl_wr),
      .rd_entry (rd_q)
   );

   rcc_table u_write_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_slot  (req_data.key_slot),
      .wr_cmd   (wr_tbl_wr),
      .rd_entry (wr_q)
   );

endmodule

`default_nettype wire
